/* hdl/tlblru_pkg.sv */
`timescale 1ns / 1ps

package tlblru_pkg;

  localparam int PAGE_BITS      = 36;
  localparam int SET_INDEX_BITS = 4;
  localparam int SET_COUNT      = 16;
  localparam int WAY_COUNT      = 4;
  localparam int WAY_BITS       = 2;
  localparam int FRAME_BITS     = 36;
  localparam int TAG_BITS       = 32;
  localparam int RANK_BITS      = 3;
  localparam int COUNT_BITS     = 3;
  localparam int SLOT_COUNT     = SET_COUNT * WAY_COUNT;
  localparam int ENTRY_BITS     = TAG_BITS + FRAME_BITS;

  typedef enum logic {
    OP_TOUCH = 1'b0,
    OP_FILL  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ACT_TOUCH   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_REJECT  = 2'd3
  } action_t;

  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [WAY_BITS-1:0]   way_t;

  typedef struct packed {
    op_t                       opcode;
    logic [PAGE_BITS-1:0]      page_number;
    logic [1:0]                touched_way;
    logic [PAGE_BITS-1:0]      frame_number;
  } cmd_t;

  typedef struct packed {
    logic [3:0] set_index;
    logic [1:0] way_used;
    action_t    action;
    logic [1:0] lru_way;
    logic       set_full;
  } rsp_t;

  typedef struct packed {
    rank_t [WAY_COUNT-1:0] ranks;
    logic  [WAY_COUNT-1:0] valid;
    count_t                count;
  } set_state_t;

  typedef struct packed {
    set_state_t state;
    way_t       way;
    action_t    action;
    way_t       lru_way;
    logic       set_full;
  } set_update_t;

endpackage

/* hdl/tlblru_ram.sv */
`timescale 1ns / 1ps

module tlblru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/tlblru_set_update.sv */
`timescale 1ns / 1ps

module tlblru_set_update (
  input  tlblru_pkg::set_state_t  cur,
  input  tlblru_pkg::op_t         opcode,
  input  tlblru_pkg::way_t        req_way,
  output tlblru_pkg::set_update_t upd
);

  localparam tlblru_pkg::count_t FULL_COUNT = tlblru_pkg::COUNT_BITS'(tlblru_pkg::WAY_COUNT);

  tlblru_pkg::way_t    oldest;
  tlblru_pkg::way_t    way;
  tlblru_pkg::way_t    lru;
  tlblru_pkg::count_t  cnt_next;
  tlblru_pkg::rank_t   prev;
  tlblru_pkg::rank_t   rank_next [tlblru_pkg::WAY_COUNT];
  tlblru_pkg::action_t act;
  logic [tlblru_pkg::WAY_COUNT-1:0] valid_next;
  logic                apply;

  always_comb begin
    oldest = '0;
    for (int w = tlblru_pkg::WAY_COUNT - 1; w >= 0; w--) begin
      if (cur.ranks[w] == tlblru_pkg::RANK_BITS'(tlblru_pkg::WAY_COUNT)) begin
        oldest = tlblru_pkg::WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    way        = req_way;
    cnt_next   = cur.count;
    valid_next = cur.valid;
    apply      = 1'b0;
    act        = tlblru_pkg::ACT_REJECT;
    if (opcode == tlblru_pkg::OP_FILL) begin
      apply = 1'b1;
      if (cur.count != FULL_COUNT) begin
        way             = cur.count[tlblru_pkg::WAY_BITS-1:0];
        cnt_next        = cur.count + tlblru_pkg::COUNT_BITS'(1);
        valid_next[way] = 1'b1;
        act             = tlblru_pkg::ACT_ADD;
      end else begin
        way = oldest;
        act = tlblru_pkg::ACT_REPLACE;
      end
    end else if ((tlblru_pkg::COUNT_BITS'(req_way) < cur.count) && cur.valid[req_way]) begin
      apply = 1'b1;
      act   = tlblru_pkg::ACT_TOUCH;
    end
  end

  always_comb begin
    prev = cur.ranks[way];
    for (int w = 0; w < tlblru_pkg::WAY_COUNT; w++) begin
      rank_next[w] = cur.ranks[w];
      if (apply && (tlblru_pkg::COUNT_BITS'(w) < cnt_next)) begin
        if (tlblru_pkg::WAY_BITS'(w) == way) begin
          rank_next[w] = tlblru_pkg::RANK_BITS'(1);
        end else if ((prev == '0) || (cur.ranks[w] <= prev)) begin
          rank_next[w] = cur.ranks[w] + tlblru_pkg::RANK_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    lru = '0;
    for (int w = tlblru_pkg::WAY_COUNT - 1; w >= 0; w--) begin
      if ((tlblru_pkg::COUNT_BITS'(w) < cnt_next) && (rank_next[w] == cnt_next)) begin
        lru = tlblru_pkg::WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < tlblru_pkg::WAY_COUNT; w++) begin
      upd.state.ranks[w] = rank_next[w];
    end
    upd.state.valid = valid_next;
    upd.state.count = cnt_next;
    upd.way         = way;
    upd.action      = act;
    upd.lru_way     = lru;
    upd.set_full    = (cnt_next == FULL_COUNT);
  end

endmodule

/* hdl/tlb_set_lru_fill_and_touch_core.sv */
`timescale 1ns / 1ps

// Set-associative TLB fill and LRU touch engine.
// Command channel: drive cmd and raise start; a transfer happens at each rising
// edge with start high and busy low. busy stays low, so a command may be sent
// in every cycle. A fill (opcode 1) places the tag and frame in the next free
// way of the set chosen by the low page bits, or replaces the least recent way
// of a full set. A touch (opcode 0) marks a filled way most recent; a touch of
// an unfilled way is reported as rejected and changes nothing.
// Response channel: rsp is valid for exactly one cycle while rsp_valid is high,
// after the command passes the input register and then one update pass
// that reads and writes the set state and loads the response register.
// Throughput is one command per cycle; back-to-back commands to the same set
// see each other's updates, as the set state is written in the same pass.
// The receiver cannot stall, so no response is ever held back.
// Synchronous reset empties every set, clears all ranks and valid bits and
// drops any command in flight. Tag and frame storage is not cleared.

module tlb_set_lru_fill_and_touch_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tlblru_pkg::cmd_t cmd,
  output logic             rsp_valid,
  output tlblru_pkg::rsp_t rsp
);

  localparam int SET_ADDR_BITS = $clog2(tlblru_pkg::SET_COUNT);

  tlblru_pkg::cmd_t       cmd_reg;
  logic                   cmd_pending;
  tlblru_pkg::set_state_t sets [tlblru_pkg::SET_COUNT];
  tlblru_pkg::set_update_t upd;
  logic [SET_ADDR_BITS-1:0] set_sel;
  logic                   entry_we;

  assign busy    = 1'b0;
  assign set_sel = cmd_reg.page_number[SET_ADDR_BITS-1:0];
  assign entry_we = cmd_pending && (cmd_reg.opcode == tlblru_pkg::OP_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_pending <= 1'b0;
    end else begin
      cmd_pending <= start;
    end
    if (start) begin
      cmd_reg <= cmd;
    end
  end

  tlblru_set_update u_update (
    .cur     (sets[set_sel]),
    .opcode  (cmd_reg.opcode),
    .req_way (cmd_reg.touched_way),
    .upd     (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < tlblru_pkg::SET_COUNT; s++) begin
        sets[s] <= '0;
      end
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= cmd_pending;
      if (cmd_pending) begin
        sets[set_sel] <= upd.state;
      end
    end
    if (cmd_pending) begin
      rsp.set_index <= 4'(set_sel);
      rsp.way_used  <= upd.way;
      rsp.action    <= upd.action;
      rsp.lru_way   <= upd.lru_way;
      rsp.set_full  <= upd.set_full;
    end
  end

  tlblru_ram #(
    .WIDTH (tlblru_pkg::ENTRY_BITS),
    .DEPTH (tlblru_pkg::SLOT_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .addr  ({set_sel, upd.way}),
    .wdata ({cmd_reg.page_number[tlblru_pkg::SET_INDEX_BITS +: tlblru_pkg::TAG_BITS],
             cmd_reg.frame_number[tlblru_pkg::FRAME_BITS-1:0]}),
    .rdata ()
  );

endmodule

/* verif/tlb_set_lru_checker.sv */
`timescale 1ns / 1ps

module tlb_set_lru_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  tlblru_pkg::cmd_t cmd,
  input  logic             rsp_valid,
  input  tlblru_pkg::rsp_t rsp,
  output int               errors,
  output int               pending,
  output int               checked,
  output int               replaced,
  output int               rejected
);

  tlblru_pkg::count_t set_fill [tlblru_pkg::SET_COUNT];
  tlblru_pkg::rank_t  way_rank [tlblru_pkg::SLOT_COUNT];
  logic               way_live [tlblru_pkg::SLOT_COUNT];
  tlblru_pkg::rsp_t   lru_updates [$];

  function automatic tlblru_pkg::way_t oldest_way(int base, int cnt);
    for (int w = 0; w < cnt; w++)
      if (way_rank[base + w] == tlblru_pkg::rank_t'(cnt)) return tlblru_pkg::way_t'(w);
    return '0;
  endfunction

  function automatic void promote(int base, int cnt, int way);
    tlblru_pkg::rank_t prev;
    prev = way_rank[base + way];
    for (int w = 0; w < cnt; w++) begin
      if (w == way) begin
        way_rank[base + w] = tlblru_pkg::rank_t'(1);
      end else if (prev == 0 || way_rank[base + w] <= prev) begin
        way_rank[base + w] = way_rank[base + w] + 1'b1;
      end
    end
  endfunction

  function automatic tlblru_pkg::rsp_t update_set_lru(tlblru_pkg::cmd_t c);
    tlblru_pkg::rsp_t r;
    int   idx;
    int   base;
    int   cnt;
    int   way;
    idx  = int'(c.page_number[tlblru_pkg::SET_INDEX_BITS-1:0]) % tlblru_pkg::SET_COUNT;
    base = idx * tlblru_pkg::WAY_COUNT;
    cnt  = int'(set_fill[idx]);
    if (cnt > tlblru_pkg::WAY_COUNT) cnt = tlblru_pkg::WAY_COUNT;
    if (c.opcode == tlblru_pkg::OP_FILL) begin
      if (cnt < tlblru_pkg::WAY_COUNT) begin
        way = cnt;
        cnt++;
        set_fill[idx] = tlblru_pkg::count_t'(cnt);
        way_live[base + way] = 1'b1;
        r.action = tlblru_pkg::ACT_ADD;
      end else begin
        way = int'(oldest_way(base, cnt));
        r.action = tlblru_pkg::ACT_REPLACE;
      end
      promote(base, cnt, way);
    end else begin
      way = int'(c.touched_way);
      if (way < cnt && way < tlblru_pkg::WAY_COUNT && way_live[base + way]) begin
        promote(base, cnt, way);
        r.action = tlblru_pkg::ACT_TOUCH;
      end else begin
        r.action = tlblru_pkg::ACT_REJECT;
      end
    end
    r.set_index = 4'(idx);
    r.way_used  = tlblru_pkg::way_t'(way);
    r.lru_way   = (cnt != 0) ? oldest_way(base, cnt) : '0;
    r.set_full  = (cnt == tlblru_pkg::WAY_COUNT);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tlblru_pkg::rsp_t want;
    if (rst) begin
      for (int s = 0; s < tlblru_pkg::SET_COUNT; s++) set_fill[s] = '0;
      for (int i = 0; i < tlblru_pkg::SLOT_COUNT; i++) begin
        way_rank[i] = '0;
        way_live[i] = 1'b0;
      end
      lru_updates.delete();
      errors   = 0;
      checked  = 0;
      replaced = 0;
      rejected = 0;
    end else begin
      if (start && !busy) lru_updates.push_back(update_set_lru(cmd));
      if (rsp_valid) begin
        if (lru_updates.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
        end else begin
          want = lru_updates.pop_front();
          checked++;
          if (want.action == tlblru_pkg::ACT_REPLACE) replaced++;
          if (want.action == tlblru_pkg::ACT_REJECT) rejected++;
          check_field("set_index", want.set_index, rsp.set_index);
          check_field("way_used", want.way_used, rsp.way_used);
          check_field("action", want.action, rsp.action);
          check_field("lru_way", want.lru_way, rsp.lru_way);
          check_field("set_full", want.set_full, rsp.set_full);
        end
      end
    end
    pending = lru_updates.size();
  end

endmodule

/* verif/tlb_set_lru_fill_and_touch_core_test.sv */
`timescale 1ns / 1ps

module tlb_set_lru_fill_and_touch_core_test;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic rsp_valid;
  tlblru_pkg::cmd_t cmd;
  tlblru_pkg::rsp_t rsp;
  int   errors;
  int   pending;
  int   checked;
  int   replaced;
  int   rejected;
  int   sent;
  bit   calm;

  tlb_set_lru_fill_and_touch_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  tlb_set_lru_checker lru_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .replaced  (replaced),
    .rejected  (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic tlblru_pkg::cmd_t make_cmd(tlblru_pkg::op_t op,
                                                logic [tlblru_pkg::PAGE_BITS-1:0] page,
                                                tlblru_pkg::way_t w,
                                                logic [tlblru_pkg::PAGE_BITS-1:0] frame);
    tlblru_pkg::cmd_t c;
    c.opcode       = op;
    c.page_number  = page;
    c.touched_way  = w;
    c.frame_number = frame;
    return c;
  endfunction

  function automatic tlblru_pkg::cmd_t random_cmd();
    tlblru_pkg::cmd_t c;
    logic [63:0] wide;
    int          idx;
    wide           = {$urandom, $urandom};
    c.page_number  = wide[tlblru_pkg::PAGE_BITS-1:0];
    wide           = {$urandom, $urandom};
    c.frame_number = wide[tlblru_pkg::PAGE_BITS-1:0];
    c.touched_way  = 2'($urandom_range(0, 3));
    c.opcode       = ($urandom_range(0, 99) < 40) ? tlblru_pkg::OP_FILL : tlblru_pkg::OP_TOUCH;
    idx = int'(c.page_number[tlblru_pkg::SET_INDEX_BITS-1:0]);
    if ($urandom_range(0, 1) == 0) idx = $urandom_range(0, 3);
    // keep a few sets sparse so partly filled sets stay around
    if (c.opcode == tlblru_pkg::OP_FILL && idx >= 12 && idx <= 14 && $urandom_range(0, 9) != 0)
      idx = $urandom_range(0, 11);
    c.page_number[tlblru_pkg::SET_INDEX_BITS-1:0] = 4'(idx);
    return c;
  endfunction

  task automatic send(tlblru_pkg::cmd_t c);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 29) gap++;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    calm  = 1'b0;
    sent  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'h000000003, 2'd0, 36'h0));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h000000000, 2'd0, 36'h000000000));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'hFFFFFFFF0, 2'd3, 36'hFFFFFFFFF));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'h000000000, 2'd2, 36'h0));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'h000000000, 2'd0, 36'h0));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h123456780, 2'd1, 36'h000000001));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h0AAAAAAA0, 2'd2, 36'h555555555));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'h000000000, 2'd3, 36'h0));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h555555550, 2'd0, 36'hAAAAAAAAA));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h800000000, 2'd0, 36'h800000000));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'h000000000, 2'd1, 36'h0));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'hFFFFFFFFF, 2'd3, 36'hFFFFFFFFF));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'h00000000F, 2'd3, 36'h0));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'h00000000F, 2'd0, 36'h0));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h00000000F, 2'd0, 36'h000000000));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h80000000F, 2'd0, 36'h7FFFFFFFF));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h7FFFFFFFF, 2'd0, 36'h0FFFFFFFF));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'h12345678F, 2'd0, 36'h123456789));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'hFFFFFFFFF, 2'd2, 36'hFFFFFFFFF));
    send(make_cmd(tlblru_pkg::OP_FILL,  36'hFEDCBA98F, 2'd1, 36'h000000000));
    send(make_cmd(tlblru_pkg::OP_TOUCH, 36'hFFFFFFFF3, 2'd3, 36'h0));
    drain();

    for (int i = 0; i < 1250; i++) begin
      calm = (i >= 500 && i < 700);
      if (i == 900) drain();
      send(random_cmd());
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Sent %0d commands, checked %0d responses: fills, touches, %0d LRU replacements",
             sent, checked, replaced);
    $display("and %0d rejected touches of unfilled ways", rejected);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
